/* design/rps_pkg.sv */
// Package for the report packet segmenter: command codes, controller states,
// register indexes, header bit positions and the read request record.
// Has no dependencies; every design file imports it.
package rps_pkg;

	localparam int FILL_W = 7;
	localparam int SIZE_W = 7;
	localparam int HDR_W = 2;
	localparam int BYTE_W = 8;
	localparam int CMD_W = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 7;
	localparam int LEN_BITS = 6;

	localparam logic [SIZE_W-1:0] MIN_REPORT_SIZE = 7'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_REPORT_SIZE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES = 1'b1;

	localparam logic [SIZE_W-1:0] REPORT_SIZE_RESET = 7'd64;
	localparam logic [HDR_W-1:0] HEADER_BYTES_RESET = 2'd1;

	localparam logic [1:0] FLAG_FIRST = 2'b10;
	localparam logic [1:0] FLAG_LAST = 2'b01;

	typedef enum logic [CMD_W-1:0] {
		CMD_START = 2'd0,
		CMD_BYTE = 2'd1,
		CMD_END = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EMIT,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic hdr_sel;
		logic [BYTE_W-1:0] hdr_val;
		logic last;
	} rd_req_t;

endpackage

/* design/report_packet_segmenter.sv */
// Channel     Handshake              Payload
// command in  in_valid / in_ready    command, payload
// report out  out_valid / out_ready  report_byte, report_end
// config      cfg_write              cfg_index, cfg_data
//
// A start, a byte that fits, and an unused command leave the controller idle.
// An emitted report of F bytes occupies the single store read port, one beat per
// cycle when the output is taken; a byte that overflows the report is written to
// the store afterward. The last beat passes the read stage and the output register
// after its read. Reset clears the fill count, flags, registers and channel state;
// the store needs no clearing. A stalled output holds the read pipeline in place.
//
// Top level of the report packet segmenter: command decoding, header build and
// emission sequencing. Depends on rps_pkg and rps_report_buf.
module report_packet_segmenter #(
	parameter int MAX_REPORT_BYTES = 64
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input logic [rps_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [rps_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic [rps_pkg::CMD_W-1:0] command,
	input logic [rps_pkg::BYTE_W-1:0] payload,
	output logic out_valid,
	input logic out_ready,
	output logic [rps_pkg::BYTE_W-1:0] report_byte,
	output logic report_end
);
	import rps_pkg::*;

	localparam int AW = $clog2(MAX_REPORT_BYTES);
	localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(MAX_REPORT_BYTES);

	state_t state_q, state_d;

	logic [SIZE_W-1:0] report_size_q;
	logic [HDR_W-1:0] header_bytes_q;
	logic [FILL_W-1:0] fill_q;
	logic [1:0] flags_q;
	logic [FILL_W-1:0] idx_q;
	logic [FILL_W-1:0] emit_cnt_q;
	logic two_hdr_q;
	logic [BYTE_W-1:0] b0_q;
	logic [BYTE_W-1:0] len_q;
	logic pend_q;
	logic [BYTE_W-1:0] pend_data_q;

	logic hdr2;
	logic [FILL_W-1:0] hdr_len;
	logic [SIZE_W-1:0] eff_size;
	logic [FILL_W-1:0] eff_fill;
	logic full;
	logic in_fire;
	logic [1:0] emit_flags;
	logic [FILL_W-1:0] emit_len;

	logic start_emit;
	logic set_start;
	logic append;
	logic do_wb;

	logic wr_en;
	logic [AW-1:0] wr_addr;
	logic [BYTE_W-1:0] wr_data;
	logic req_valid;
	logic req_ready;
	rd_req_t req;
	logic req_last;

	assign hdr2 = header_bytes_q >= 2'd2;
	assign hdr_len = hdr2 ? 7'd2 : 7'd1;

	always_comb begin
		eff_size = report_size_q;
		if (eff_size < MIN_REPORT_SIZE) begin
			eff_size = MIN_REPORT_SIZE;
		end
		if (eff_size > MAX_SIZE) begin
			eff_size = MAX_SIZE;
		end
		eff_fill = fill_q;
		if (eff_fill < hdr_len) begin
			eff_fill = hdr_len;
		end
		if (eff_fill > eff_size) begin
			eff_fill = eff_size;
		end
	end

	assign full = eff_fill >= eff_size;
	assign in_ready = state_q == ST_IDLE;
	assign in_fire = in_valid && in_ready;
	assign emit_len = eff_fill - hdr_len;
	assign emit_flags = (command == CMD_END) ? (flags_q | FLAG_LAST) : flags_q;
	assign req_last = (idx_q + 7'd1) == emit_cnt_q;

	always_comb begin
		state_d = state_q;
		start_emit = 1'b0;
		set_start = 1'b0;
		append = 1'b0;
		do_wb = 1'b0;
		req_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					case (command)
						CMD_START: begin
							set_start = 1'b1;
						end
						CMD_BYTE: begin
							if (full) begin
								start_emit = 1'b1;
								state_d = ST_EMIT;
							end else begin
								append = 1'b1;
							end
						end
						CMD_END: begin
							start_emit = 1'b1;
							state_d = ST_EMIT;
						end
						default: begin
						end
					endcase
				end
			end
			ST_EMIT: begin
				req_valid = 1'b1;
				if (req_ready && req_last) begin
					state_d = pend_q ? ST_WRITE : ST_IDLE;
				end
			end
			ST_WRITE: begin
				do_wb = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_size_q <= REPORT_SIZE_RESET;
			header_bytes_q <= HEADER_BYTES_RESET;
			fill_q <= '0;
			flags_q <= '0;
			idx_q <= '0;
			pend_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_REPORT_SIZE: report_size_q <= cfg_data[SIZE_W-1:0];
					CFG_HEADER_BYTES: header_bytes_q <= cfg_data[HDR_W-1:0];
					default: begin
					end
				endcase
			end
			if (set_start) begin
				flags_q <= FLAG_FIRST;
				fill_q <= hdr_len;
			end
			if (append) begin
				fill_q <= eff_fill + 7'd1;
			end
			if (start_emit) begin
				flags_q <= '0;
				fill_q <= hdr_len;
				idx_q <= '0;
				pend_q <= command == CMD_BYTE;
			end
			if (req_valid && req_ready) begin
				idx_q <= idx_q + 7'd1;
			end
			if (do_wb) begin
				fill_q <= hdr_len + 7'd1;
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_emit) begin
			emit_cnt_q <= eff_fill;
			two_hdr_q <= hdr2;
			b0_q <= {emit_flags, hdr2 ? 6'd0 : emit_len[LEN_BITS-1:0]};
			len_q <= {1'b0, emit_len};
			pend_data_q <= payload;
		end
	end

	always_comb begin
		wr_en = append || do_wb;
		wr_addr = do_wb ? hdr_len[AW-1:0] : eff_fill[AW-1:0];
		wr_data = do_wb ? pend_data_q : payload;
		req.hdr_sel = (idx_q == 7'd0) || ((idx_q == 7'd1) && two_hdr_q);
		req.hdr_val = (idx_q == 7'd0) ? b0_q : len_q;
		req.last = req_last;
	end

	rps_report_buf #(
		.DEPTH(MAX_REPORT_BYTES)
	) u_buf (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_addr(idx_q[AW-1:0]),
		.req(req),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.report_byte(report_byte),
		.report_end(report_end)
	);

endmodule

/* design/rps_report_buf.sv */
// Report byte store with a registered read port, a read stage and the output
// register that drives the result channel.
// Depends on rps_pkg for the read request record.
module rps_report_buf #(
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [$clog2(DEPTH)-1:0] wr_addr,
	input logic [rps_pkg::BYTE_W-1:0] wr_data,
	input logic req_valid,
	output logic req_ready,
	input logic [$clog2(DEPTH)-1:0] req_addr,
	input rps_pkg::rd_req_t req,
	output logic out_valid,
	input logic out_ready,
	output logic [rps_pkg::BYTE_W-1:0] report_byte,
	output logic report_end
);
	import rps_pkg::*;

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [BYTE_W-1:0] rdata_s1;
	rd_req_t meta_s1;
	logic valid_s1;
	logic out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic out_end_q;
	logic adv;
	logic rd_fire;

	assign adv = valid_s1 && (!out_valid_q || out_ready);
	assign req_ready = !valid_s1 || adv;
	assign rd_fire = req_valid && req_ready;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_fire) begin
			rdata_s1 <= mem[req_addr];
			meta_s1 <= req;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q <= meta_s1.hdr_sel ? meta_s1.hdr_val : rdata_s1;
			out_end_q <= meta_s1.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rd_fire) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign report_byte = out_byte_q;
	assign report_end = out_end_q;

endmodule

/* verif/report_packet_segmenter_tb.sv */
// Self-checking testbench for report_packet_segmenter: directed and random command
// streams with bursty input and a stalling output, checked beat by beat against an
// in-bench segmentation model. Depends on rps_pkg and the segmenter RTL.
`timescale 1ns / 1ps

module report_packet_segmenter_tb;
	import rps_pkg::*;

	localparam int REPORT_CAP = 64;
	localparam int SETTLE_CYCLES = 12;
	localparam int QUIET_LIMIT = 4000;
	localparam int LONG_HOLD = 300;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0] code;
		logic [BYTE_W-1:0] data;
	} seg_cmd_t;

	typedef struct packed {
		logic [BYTE_W-1:0] value;
		logic last;
	} report_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [CMD_W-1:0] command = CMD_START;
	logic [BYTE_W-1:0] payload = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [BYTE_W-1:0] report_byte;
	logic report_end;

	// Segmentation model state.
	logic [BYTE_W-1:0] seg_store [REPORT_CAP];
	logic [FILL_W-1:0] seg_fill = '0;
	logic [1:0] seg_flags = '0;
	logic [SIZE_W-1:0] seg_size = REPORT_SIZE_RESET;
	logic [HDR_W-1:0] seg_hdr = HEADER_BYTES_RESET;

	seg_cmd_t cmd_q[$];
	report_beat_t report_beats[$];
	seg_cmd_t cur_cmd;
	report_beat_t want;
	logic send_next;
	logic take_next;
	int long_hold_reqs = 0;
	int long_hold_seen;
	int burst_left, gap_left;
	int hold_left, ready_mode, mode_left, rx_tick;
	int quiet_cycles = 0;
	int n_queued = 0;
	int n_cmds = 0;
	int n_beats = 0;
	int n_reports = 0;
	int n_settings = 0;
	int n_in_stalls = 0;
	int n_errors = 0;

	report_packet_segmenter #(
		.MAX_REPORT_BYTES(REPORT_CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.payload(payload),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.report_byte(report_byte),
		.report_end(report_end)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int hdr_len();
		return (seg_hdr >= 2'd2) ? 2 : 1;
	endfunction

	function automatic int size_lim();
		int s;
		s = seg_size;
		if (s < int'(MIN_REPORT_SIZE)) s = int'(MIN_REPORT_SIZE);
		if (s > REPORT_CAP) s = REPORT_CAP;
		return s;
	endfunction

	function automatic int fill_at();
		int f;
		f = seg_fill;
		if (f < hdr_len()) f = hdr_len();
		if (f > size_lim()) f = size_lim();
		return f;
	endfunction

	task automatic flush_report();
		int h, f, len;
		logic [BYTE_W-1:0] head;
		report_beat_t beat;
		h = hdr_len();
		f = fill_at();
		len = f - h;
		head = '0;
		head[7] = (seg_flags & FLAG_FIRST) != 0;
		head[6] = (seg_flags & FLAG_LAST) != 0;
		head[LEN_BITS-1:0] = (h == 2) ? LEN_BITS'(len >> 8) : LEN_BITS'(len);
		for (int i = 0; i < f; i++) begin
			if (i == 0)
				beat.value = head;
			else if (i == 1 && h == 2)
				beat.value = BYTE_W'(len);
			else
				beat.value = seg_store[i % REPORT_CAP];
			beat.last = (i == f - 1);
			report_beats.push_back(beat);
		end
		seg_flags = '0;
		seg_fill = FILL_W'(h);
	endtask

	task automatic apply_command(input seg_cmd_t c);
		int f;
		case (c.code)
			CMD_START: begin
				seg_flags = FLAG_FIRST;
				seg_fill = FILL_W'(hdr_len());
			end
			CMD_BYTE: begin
				f = fill_at();
				if (f >= size_lim()) begin
					flush_report();
					f = fill_at();
				end
				seg_store[f % REPORT_CAP] = c.data;
				seg_fill = FILL_W'(f + 1);
			end
			CMD_END: begin
				seg_flags = seg_flags | FLAG_LAST;
				flush_report();
			end
			default: ;
		endcase
	endtask

	task automatic queue_cmd(input logic [CMD_W-1:0] code, input logic [BYTE_W-1:0] data);
		seg_cmd_t c;
		c.code = code;
		c.data = data;
		cmd_q.push_back(c);
		if (code != CMD_UNUSED) n_queued++;
	endtask

	task automatic queue_packet(input int nbytes, input bit closed);
		queue_cmd(CMD_START, 8'($urandom));
		for (int i = 0; i < nbytes; i++) queue_cmd(CMD_BYTE, 8'($urandom));
		if (closed) queue_cmd(CMD_END, 8'($urandom));
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (cmd_q.size() != 0 || in_valid || report_beats.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reconfigure(input logic [CFG_DATA_W-1:0] size_word,
			input logic [CFG_DATA_W-1:0] hdr_word);
		wait_drained();
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= CFG_REPORT_SIZE;
		cfg_data <= size_word;
		@(posedge clk);
		cfg_index <= CFG_HEADER_BYTES;
		cfg_data <= hdr_word;
		@(posedge clk);
		cfg_write <= 1'b0;
		seg_size = size_word;
		seg_hdr = hdr_word[HDR_W-1:0];
		n_settings++;
		@(negedge clk);
	endtask

	// Sender: bursts of random length separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			send_next = in_valid;
			if (in_valid && in_ready) begin
				apply_command(cur_cmd);
				n_cmds++;
				send_next = 1'b0;
			end else if (in_valid) begin
				n_in_stalls++;
			end
			if (!send_next) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (cmd_q.size() != 0) begin
					cur_cmd = cmd_q.pop_front();
					command <= cur_cmd.code;
					payload <= cur_cmd.data;
					send_next = 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 11);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
			in_valid <= send_next;
		end
	end

	// Receiver: checks every report beat and stalls on its own pattern.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left = 0;
			ready_mode = 0;
			mode_left = 0;
			rx_tick = 0;
			long_hold_seen = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (report_beats.size() == 0) begin
					$display("%0t: unexpected beat, byte %02h end %b", $time, report_byte,
						report_end);
					n_errors++;
				end else begin
					want = report_beats.pop_front();
					if (report_byte !== want.value) begin
						$display("%0t: report_byte expected %02h, got %02h", $time,
							want.value, report_byte);
						n_errors++;
					end
					if (report_end !== want.last) begin
						$display("%0t: report_end expected %b, got %b", $time, want.last,
							report_end);
						n_errors++;
					end
				end
				n_beats++;
				if (report_end) n_reports++;
			end
			if (long_hold_seen != long_hold_reqs) begin
				hold_left = LONG_HOLD;
				long_hold_seen = long_hold_reqs;
			end
			if (mode_left == 0) begin
				ready_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 80);
			end else begin
				mode_left--;
			end
			rx_tick++;
			if (hold_left > 0) begin
				hold_left--;
				take_next = 1'b0;
			end else begin
				case (ready_mode)
					0: take_next = 1'b1;
					1: take_next = $urandom_range(0, 3) != 0;
					2: take_next = $urandom_range(0, 2) == 0;
					default: take_next = (rx_tick % 8) < 5;
				endcase
			end
			out_ready <= take_next;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		logic [CFG_DATA_W-1:0] size_word, hdr_word;
		int cap, n, pick, phase, phase_start, rand_base;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: bytes and ends before any start, an unused code, empty reports.
		queue_cmd(CMD_BYTE, 8'h00);
		queue_cmd(CMD_END, 8'hff);
		queue_cmd(CMD_END, 8'h00);
		queue_cmd(CMD_UNUSED, 8'hff);
		queue_cmd(CMD_START, 8'h00);
		queue_cmd(CMD_END, 8'h00);
		queue_cmd(CMD_START, 8'hff);
		queue_cmd(CMD_BYTE, 8'hff);
		queue_cmd(CMD_BYTE, 8'h5a);
		queue_cmd(CMD_END, 8'hff);

		// Smallest report with a two-byte header: every byte after the first overflows the report.
		reconfigure(7'd3, 7'h7e);
		queue_cmd(CMD_START, 8'h00);
		queue_cmd(CMD_BYTE, 8'ha5);
		queue_cmd(CMD_BYTE, 8'h3c);
		queue_cmd(CMD_BYTE, 8'hc3);
		queue_cmd(CMD_END, 8'h00);

		// Size below the minimum and a zero header register.
		reconfigure(7'd2, 7'h00);
		queue_cmd(CMD_START, 8'h00);
		queue_cmd(CMD_BYTE, 8'hff);
		queue_cmd(CMD_BYTE, 8'h00);
		queue_cmd(CMD_BYTE, 8'h81);
		queue_cmd(CMD_END, 8'h00);

		// Oversized register, then the size is lowered under an open report.
		reconfigure(7'h7f, 7'h7f);
		queue_cmd(CMD_START, 8'h00);
		queue_cmd(CMD_BYTE, 8'h01);
		queue_cmd(CMD_BYTE, 8'h80);
		queue_cmd(CMD_BYTE, 8'hfe);
		queue_cmd(CMD_BYTE, 8'h7f);
		reconfigure(7'd4, 7'h03);
		queue_cmd(CMD_BYTE, 8'h11);
		queue_cmd(CMD_END, 8'h00);

		phase = 0;
		rand_base = n_queued;
		while (n_queued - rand_base < 180) begin
			if (phase == 0 || phase == 3)
				size_word = CFG_DATA_W'($urandom_range(3, 4));
			else if (phase == 2)
				size_word = ($urandom_range(0, 1) == 0) ? 7'd64 : 7'd127;
			else if ($urandom_range(0, 4) == 0)
				size_word = CFG_DATA_W'($urandom_range(0, 2));
			else
				size_word = CFG_DATA_W'($urandom_range(3, 10));
			hdr_word = {5'($urandom), 2'($urandom_range(0, 3))};
			reconfigure(size_word, hdr_word);
			// The receiver holds off while the sender keeps offering commands.
			if (phase == 0 || phase == 3) long_hold_reqs++;
			cap = size_lim() - hdr_len();
			if (phase == 2)
				queue_packet(cap + 1, 1'b1);
			else
				queue_packet($urandom_range(0, 2 * cap + 1), 1'b1);
			phase_start = n_queued;
			while (n_queued - phase_start < 30) begin
				pick = $urandom_range(0, 19);
				if ($urandom_range(0, 3) == 0)
					n = cap * $urandom_range(1, 2);
				else
					n = $urandom_range(0, 2 * cap + 1);
				if (n > 24) n = $urandom_range(0, 24);
				case (pick)
					0: queue_cmd(CMD_BYTE, 8'($urandom));
					1: queue_cmd(CMD_END, 8'($urandom));
					2: queue_cmd(CMD_UNUSED, 8'($urandom));
					3: queue_packet(n, 1'b0);
					default: queue_packet(n, 1'b1);
				endcase
			end
			phase++;
		end

		wait_drained();
		$display("Sent %0d commands under %0d register settings; checked %0d beats in %0d reports.",
			n_cmds, n_settings + 1, n_beats, n_reports);
		$display("The block held off offered commands for %0d cycles in total.", n_in_stalls);
		if (n_errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

/* filelist.f */
design/rps_pkg.sv
design/rps_report_buf.sv
design/report_packet_segmenter.sv
verif/report_packet_segmenter_tb.sv
